>>> hdl/ccr_pkg.sv
// ccr_pkg: shared constants, state type and controller/datapath interface structs
// for the chain code rescaler. No dependencies.
`default_nettype none

package ccr_pkg;

   // fixed field and register widths
   localparam int IN_COORD_W  = 12;
   localparam int CODE_W      = 8;
   localparam int POS_BITS    = 35;
   localparam int SCALE_BITS  = 22;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // default parameter values
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;

   // result count limit per transaction
   localparam int MAX_EMIT = 64;
   localparam int CNT_BITS = 7;

   // register map (index = byte address / 4)
   localparam logic REG_SCALE = 1'b0;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 22'd65536;

   // chain code characters
   localparam logic [CODE_W-1:0] CODE_LEFT  = 8'h34;  // '4'
   localparam logic [CODE_W-1:0] CODE_RIGHT = 8'h36;  // '6'
   localparam logic [CODE_W-1:0] CODE_UP    = 8'h38;  // '8'
   localparam logic [CODE_W-1:0] CODE_DOWN  = 8'h32;  // '2'

   // input kind
   localparam logic KIND_START = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MOVE,
      ST_COUNT,
      ST_EMIT
   } ccr_state_type;

   typedef struct packed {
      logic load;
      logic mul_x;
      logic mul_y;
      logic move;
      logic count;
      logic emit;
   } ccr_cmd_type;

   typedef struct packed {
      logic in_start;
      logic in_move;
      logic cross_zero;
      logic cnt_last;
      logic out_free;
   } ccr_status_type;

endpackage

`default_nettype wire

>>> hdl/ccr_ctrl.sv
// ccr_ctrl: sequencing state machine for the chain code rescaler.
// Depends on ccr_pkg; drives commands to ccr_dp and reads its status.
`default_nettype none

module ccr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ccr_pkg::ccr_status_type status,
   output ccr_pkg::ccr_cmd_type        cmd
);
   import ccr_pkg::*;

   ccr_state_type state_ff;
   ccr_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               if (status.in_start) begin
                  state_in = ST_MUL_X;
               end else if (status.in_move) begin
                  state_in = ST_MOVE;
               end
            end
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = status.cross_zero ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.cnt_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/ccr_dp.sv
// ccr_dp: position registers, shared multiplier, cell crossing count and
// result register. Depends on ccr_pkg; controlled by ccr_ctrl.
`default_nettype none

module ccr_dp #(
   parameter int COORD_BITS = ccr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ccr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_kind,
   input  wire logic [ccr_pkg::IN_COORD_W-1:0]  req_start_x,
   input  wire logic [ccr_pkg::IN_COORD_W-1:0]  req_start_y,
   input  wire logic [ccr_pkg::CODE_W-1:0]      req_step_code,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ccr_pkg::CODE_W-1:0]           rsp_out_step,
   output logic                                 rsp_last,
   input  wire logic [ccr_pkg::SCALE_BITS-1:0]  scale,
   input  wire ccr_pkg::ccr_cmd_type            cmd,
   output ccr_pkg::ccr_status_type              status
);
   import ccr_pkg::*;

   localparam int USE_BITS  = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
   localparam int PROD_W    = USE_BITS + SCALE_BITS;
   localparam int CELL_BITS = POS_BITS - FRAC_BITS;

   logic [USE_BITS-1:0]  x_ff, y_ff;
   logic [CODE_W-1:0]    code_ff;
   logic                 axis_ff, up_ff;
   logic [POS_BITS-1:0]  pos_x_ff, pos_y_ff;
   logic [CELL_BITS-1:0] old_cell_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [CODE_W-1:0]    rsp_step_ff;

   logic                 code_ok, code_axis, code_up;
   logic [USE_BITS-1:0]  mul_a;
   logic [PROD_W-1:0]    prod;
   logic [POS_BITS-1:0]  pos_sel, pos_step, scale_ext;
   logic [CELL_BITS-1:0] new_cell, crossed;
   logic [CNT_BITS-1:0]  crossed_sat;
   logic                 out_free;

   // decode the incoming step code
   always_comb begin
      code_ok   = 1'b1;
      code_axis = 1'b0;
      code_up   = 1'b0;
      case (req_step_code)
         CODE_LEFT:  begin code_axis = 1'b0; code_up = 1'b0; end
         CODE_RIGHT: begin code_axis = 1'b0; code_up = 1'b1; end
         CODE_UP:    begin code_axis = 1'b1; code_up = 1'b0; end
         CODE_DOWN:  begin code_axis = 1'b1; code_up = 1'b1; end
         default:    code_ok = 1'b0;
      endcase
   end

   // shared multiplier for the start position
   assign mul_a = cmd.mul_y ? y_ff : x_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(scale);

   // move along the selected axis
   assign pos_sel   = axis_ff ? pos_y_ff : pos_x_ff;
   assign scale_ext = POS_BITS'(scale);
   assign pos_step  = up_ff ? (pos_sel + scale_ext) : (pos_sel - scale_ext);

   // cells crossed in the direction of motion, saturated
   assign new_cell    = pos_sel[POS_BITS-1:FRAC_BITS];
   assign crossed     = up_ff ? (new_cell - old_cell_ff) : (old_cell_ff - new_cell);
   assign crossed_sat = (crossed > CELL_BITS'(MAX_EMIT)) ? CNT_BITS'(MAX_EMIT)
                                                         : crossed[CNT_BITS-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // transaction payload capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_start_x[USE_BITS-1:0];
         y_ff    <= req_start_y[USE_BITS-1:0];
         code_ff <= req_step_code;
         axis_ff <= code_axis;
         up_ff   <= code_up;
      end
   end

   // position state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         if (cmd.mul_x) begin
            pos_x_ff <= POS_BITS'(prod);
         end else if (cmd.move && !axis_ff) begin
            pos_x_ff <= pos_step;
         end
         if (cmd.mul_y) begin
            pos_y_ff <= POS_BITS'(prod);
         end else if (cmd.move && axis_ff) begin
            pos_y_ff <= pos_step;
         end
      end
   end

   // old cell and result count
   always_ff @(posedge clock) begin
      if (cmd.move) begin
         old_cell_ff <= pos_sel[POS_BITS-1:FRAC_BITS];
      end
      if (cmd.count) begin
         cnt_ff <= crossed_sat;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_step_ff <= code_ff;
         rsp_last_ff <= (cnt_ff == CNT_BITS'(1));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_step = rsp_step_ff;
   assign rsp_last     = rsp_last_ff;

   // status to the controller
   always_comb begin
      status            = '0;
      status.in_start   = (req_kind == KIND_START);
      status.in_move    = (req_kind != KIND_START) && code_ok;
      status.cross_zero = (crossed_sat == '0);
      status.cnt_last   = (cnt_ff == CNT_BITS'(1));
      status.out_free   = out_free;
   end

endmodule

`default_nettype wire

>>> hdl/chain_code_rescaler.sv
// chain_code_rescaler: top level with the scale register on the APB-style port,
// the controller ccr_ctrl and the datapath ccr_dp. Depends on ccr_pkg.
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       req_kind, req_start_x, req_start_y,
//                                                   req_step_code
//   rsp      out        rsp_valid / rsp_stall       rsp_out_step, rsp_last
//   csr      in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// a start transaction is accepted, then x and y go in turn through one shared multiplier
// a step transaction is accepted, moved and counted, then emits 0 to 64 results, one per cycle while rsp_stall allows
// any other code is consumed in the accept cycle
// the result register lets the next transaction be accepted while the last result waits
// rsp_stall holds the result register and the emitting controller in place
// synchronous reset clears the positions to zero and the scale to 1.0
`default_nettype none

module chain_code_rescaler #(
   parameter int COORD_BITS = ccr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ccr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_kind,
   input  wire logic [ccr_pkg::IN_COORD_W-1:0]  req_start_x,
   input  wire logic [ccr_pkg::IN_COORD_W-1:0]  req_start_y,
   input  wire logic [ccr_pkg::CODE_W-1:0]      req_step_code,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [ccr_pkg::CODE_W-1:0]           rsp_out_step,
   output logic                                 rsp_last,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ccr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [ccr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ccr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import ccr_pkg::*;

   logic [SCALE_BITS-1:0] scale_ff;
   logic                  csr_wr;
   ccr_cmd_type           cmd;
   ccr_status_type        status;

   // configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == REG_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         scale_ff <= pwdata[SCALE_BITS-1:0];
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == REG_SCALE) begin
         prdata = CSR_DATA_W'(scale_ff);
      end
   end

   ccr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccr_dp #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_kind),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_step_code (req_step_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_step  (rsp_out_step),
      .rsp_last      (rsp_last),
      .scale         (scale_ff),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

>>> hdl/ccr_checker.sv
// ccr_checker: port-level assertions for chain_code_rescaler, bound to the top level.
// Depends on ccr_pkg.
`default_nettype none

module ccr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            req_kind,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [ccr_pkg::CODE_W-1:0]      rsp_out_step,
   input wire logic                            rsp_last
);
   import ccr_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_step) && $stable(rsp_last))
      else $error("stalled result changed");

   // only the four move codes are ever emitted
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_step == CODE_LEFT) || (rsp_out_step == CODE_RIGHT)
                    || (rsp_out_step == CODE_UP) || (rsp_out_step == CODE_DOWN))
      else $error("result carries an unknown code");

   // results of one transaction come back to back while the sink takes them
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a result burst");

   // a start transaction keeps the block busy during its multiply
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_START) |=> req_stall)
      else $error("start transaction did not occupy the block");

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind chain_code_rescaler ccr_checker u_ccr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_step (rsp_out_step),
   .rsp_last     (rsp_last)
);

`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for chain_code_rescaler, with a driver, a monitor,
// a path predictor and an APB-style scale register writer. Depends on ccr_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ccr_pkg::*;

   localparam int FRAC           = FRAC_BITS_DEF;
   localparam int CELL_BITS      = POS_BITS - FRAC;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 270;
   localparam int PRINT_CAP      = 40;
   localparam logic KIND_STEP    = ~KIND_START;
   localparam logic [CSR_ADDR_W-1:0] SCALE_ADDR = CSR_ADDR_W'(4 * REG_SCALE);
   localparam logic [SCALE_BITS-1:0] SCALE_MAX  = 22'd4194303;

   typedef struct packed {
      logic                  kind;
      logic [IN_COORD_W-1:0] sx;
      logic [IN_COORD_W-1:0] sy;
      logic [CODE_W-1:0]     code;
   } path_item_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic              last;
   } emitted_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_START;
   logic [IN_COORD_W-1:0] req_start_x = '0;
   logic [IN_COORD_W-1:0] req_start_y = '0;
   logic [CODE_W-1:0]     req_step_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_out_step;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // pending path items and the steps they are predicted to emit
   path_item_type    path_items[$];
   emitted_step_type steps_due[$];

   // predictor copy of the block state
   logic [POS_BITS-1:0]   pos_x_model = '0;
   logic [POS_BITS-1:0]   pos_y_model = '0;
   logic [SCALE_BITS-1:0] scale_model = SCALE_RESET;

   int mismatch_count = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;

   chain_code_rescaler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_step_code(req_step_code),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_step(rsp_out_step), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // idle length: mostly short, a few long, none in calm phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // advance the scaled position and queue the steps the item emits
   function automatic void rescale_item(input path_item_type it);
      logic [POS_BITS-1:0]  was;
      logic [POS_BITS-1:0]  moved;
      logic [CELL_BITS-1:0] crossed;
      logic                 on_x;
      logic                 rising;
      int                   n;
      if (it.kind == KIND_START) begin
         pos_x_model = POS_BITS'(64'(it.sx) * 64'(scale_model));
         pos_y_model = POS_BITS'(64'(it.sy) * 64'(scale_model));
         return;
      end
      case (it.code)
         CODE_LEFT: begin
            on_x = 1'b1; rising = 1'b0;
         end
         CODE_RIGHT: begin
            on_x = 1'b1; rising = 1'b1;
         end
         CODE_UP: begin
            on_x = 1'b0; rising = 1'b0;
         end
         CODE_DOWN: begin
            on_x = 1'b0; rising = 1'b1;
         end
         default: return;
      endcase
      was = on_x ? pos_x_model : pos_y_model;
      moved = rising ? was + POS_BITS'(scale_model) : was - POS_BITS'(scale_model);
      // floor cells wrap, crossings counted in the direction of motion
      if (rising)
         crossed = moved[POS_BITS-1:FRAC] - was[POS_BITS-1:FRAC];
      else
         crossed = was[POS_BITS-1:FRAC] - moved[POS_BITS-1:FRAC];
      n = (crossed > MAX_EMIT) ? MAX_EMIT : int'(crossed);
      for (int k = 0; k < n; k++)
         steps_due.push_back('{code: it.code, last: (k == n - 1)});
      if (on_x)
         pos_x_model = moved;
      else
         pos_y_model = moved;
   endfunction

   // driver: presents queued path items, predicts at acceptance
   path_item_type driving;
   int            req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            rescale_item(driving);
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (path_items.size() != 0) begin
               driving = path_items.pop_front();
               req_kind <= driving.kind;
               req_start_x <= driving.sx;
               req_start_y <= driving.sy;
               req_step_code <= driving.code;
               req_valid <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stall, compares each result transaction with the oldest step due
   int hold_left = 0;

   always @(posedge clock) begin
      emitted_step_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (steps_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result step %h last %b",
                                         rsp_out_step, rsp_last));
            end else begin
               want = steps_due.pop_front();
               if (rsp_out_step !== want.code)
                  report_mismatch($sformatf("out_step %h, expected %h", rsp_out_step, want.code));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_start(input int x, input int y);
      path_items.push_back('{kind: KIND_START, sx: IN_COORD_W'(x), sy: IN_COORD_W'(y),
                             code: CODE_W'($urandom)});
   endtask

   task automatic push_step(input logic [CODE_W-1:0] code);
      path_items.push_back('{kind: KIND_STEP, sx: IN_COORD_W'($urandom),
                             sy: IN_COORD_W'($urandom), code: code});
   endtask

   // wait until every item is taken and every step has come, then let the block settle
   task automatic wait_quiet();
      while (path_items.size() != 0 || req_valid || steps_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // scale register write, then read back
   task automatic write_scale(input logic [SCALE_BITS-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SCALE_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      scale_model = value;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value))
         report_mismatch($sformatf("scale read %h, expected %h", prdata, value));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] pick_direction();
      case ($urandom_range(0, 3))
         0: return CODE_LEFT;
         1: return CODE_RIGHT;
         2: return CODE_UP;
         default: return CODE_DOWN;
      endcase
   endfunction

   // stimulus: directed paths, then random paths under random scales
   initial begin
      int counted;
      int phase_len;
      int r;
      logic [CODE_W-1:0] dir;
      logic [CODE_W-1:0] odd_code;
      logic [SCALE_BITS-1:0] scale;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset scale of one: steps before start, moves below zero, ignored codes
      calm = 1'b0;
      push_step(CODE_RIGHT);
      push_step(CODE_LEFT);
      push_step(CODE_LEFT);
      push_step(CODE_UP);
      push_step(CODE_DOWN);
      push_step(8'h00);
      push_step(8'hFF);
      push_step(8'h35);
      push_start(4095, 4095);
      push_step(CODE_DOWN);
      push_step(CODE_RIGHT);
      push_start(0, 0);
      wait_quiet();

      // largest scale: most crossings per step
      write_scale(SCALE_MAX);
      push_start(4095, 4095);
      push_step(CODE_LEFT);
      push_step(CODE_RIGHT);
      push_step(CODE_UP);
      push_step(CODE_DOWN);
      push_start(0, 0);
      push_step(CODE_LEFT);
      push_step(CODE_UP);
      wait_quiet();

      // zero scale moves nothing
      write_scale('0);
      push_step(CODE_RIGHT);
      push_start(123, 4000);
      push_step(CODE_DOWN);
      wait_quiet();

      // smallest nonzero scale
      write_scale(22'd1);
      push_step(CODE_RIGHT);
      push_step(CODE_LEFT);
      wait_quiet();

      // random paths: a start, then runs of steps with some noise codes and occasional new starts
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            scale = SCALE_BITS'($urandom_range(1, 65535));
         else if (r < 75)
            scale = SCALE_BITS'($urandom_range(65536, 6 * 65536));
         else if (r < 90)
            scale = SCALE_BITS'($urandom_range(6 * 65536, SCALE_MAX));
         else
            scale = ($urandom_range(0, 1) != 0) ? SCALE_MAX : 22'd1;
         write_scale(scale);
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 60);
         dir = pick_direction();
         push_start($urandom_range(0, 4095), $urandom_range(0, 4095));
         counted++;
         for (int i = 0; i < phase_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               push_start($urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (r < 90) begin
               if ($urandom_range(0, 9) >= 7)
                  dir = pick_direction();
               push_step(dir);
            end else begin
               odd_code = CODE_W'($urandom_range(0, 255));
               push_step(odd_code);
            end
            counted++;
         end
         wait_quiet();
      end

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
